// ----- rtl/core/hm8_pkg.sv -----
// ----------------------------------------------------------------------------
// hm8_pkg
// Shared types and constants for the histogram median block.
// ----------------------------------------------------------------------------
package hm8_pkg;

    localparam int MAX_COUNT_DEF = 256;
    localparam int NUM_BINS_DEF  = 256;
    localparam int SAMPLE_W      = 8;
    localparam int OUT_W         = 9;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // input beat taken this cycle
        logic inc;      // write back incremented bin
        logic clear;    // zeroing sweep after reset
        logic scan;     // cumulative scan, clears bins as it goes
        logic load;     // load result register, reset set state
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic sweep_last;   // sweep index at top bin
        logic out_free;     // result register can take a new value
    } t_sts;

endpackage

// ----- rtl/core/histogram_median_8bit.sv -----
// ----------------------------------------------------------------------------
// histogram_median_8bit
// Median of a set of 8-bit samples found through a bin histogram.
// ----------------------------------------------------------------------------
// Input channel: one sample per beat (i_valid / o_stall), i_last_item closes
// the set. Output channel: one result beat per set (o_valid / i_stall) with
// twice the median, the counted set size and the overflow flag.
// Samples past MAX_COUNT are dropped and reported through o_overflowed.
// Each sample is read from its bin and then written back incremented, with
// o_stall high during the write-back. A closing sample adds a scan of all
// NUM_BINS bins, during which each bin is read, accumulated and zeroed, then
// a drain state; o_valid rises once the result register is loaded.
// The result sits in an output register; new samples are taken while it
// waits. A finished scan holds until that register is free.
// After reset the bin memory is zeroed by a sweep over all bins with
// o_stall high. i_stall holds the result beat, and so the next set's result.
// ----------------------------------------------------------------------------
module histogram_median_8bit #(
    parameter int MAX_COUNT = hm8_pkg::MAX_COUNT_DEF,
    parameter int NUM_BINS  = hm8_pkg::NUM_BINS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [hm8_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic                         i_last_item,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [hm8_pkg::OUT_W-1:0]    o_median_doubled,
    output logic [hm8_pkg::OUT_W-1:0]    o_set_size,
    output logic                         o_overflowed
);
    import hm8_pkg::*;

    t_cmd cmd;
    t_sts sts;

    hm8_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last_item (i_last_item),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_stall     (o_stall)
    );

    hm8_dpath #(
        .MAX_COUNT (MAX_COUNT),
        .NUM_BINS  (NUM_BINS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_sample_value   (i_sample_value),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_median_doubled (o_median_doubled),
        .o_set_size       (o_set_size),
        .o_overflowed     (o_overflowed)
    );

endmodule

// ----- rtl/core/hm8_ctrl.sv -----
// ----------------------------------------------------------------------------
// hm8_ctrl
// Sequencer: clearing sweep, per-sample increment, median scan, result load.
// ----------------------------------------------------------------------------
module hm8_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_last_item,
    input  hm8_pkg::t_sts i_sts,
    output hm8_pkg::t_cmd o_cmd,
    output logic          o_stall
);
    import hm8_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INC,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_stall;
    logic   r_last, n_last;
    logic   accept;

    assign accept = i_valid && !r_stall;

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.sweep_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_INC;
                    n_last  = i_last_item;
                end
            end
            ST_INC: begin
                n_state = r_last ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                if (i_sts.sweep_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_stall <= 1'b1;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= (n_state != ST_IDLE);
            r_last  <= n_last;
        end
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = accept;
        o_cmd.inc    = (r_state == ST_INC);
        o_cmd.clear  = (r_state == ST_CLEAR);
        o_cmd.scan   = (r_state == ST_SCAN);
        o_cmd.load   = (r_state == ST_FINISH) && i_sts.out_free;
    end

    assign o_stall = r_stall;

`ifndef ASSERT_OFF
    a_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_stall |-> r_state == ST_IDLE)
        else $error("input ready outside idle");
    a_scan_to_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_sts.sweep_last) |=> r_state == ST_DRAIN)
        else $error("scan did not finish at top bin");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.inc, o_cmd.clear, o_cmd.scan, o_cmd.load}))
        else $error("conflicting datapath commands");
`endif

endmodule

// ----- rtl/core/hm8_dpath.sv -----
// ----------------------------------------------------------------------------
// hm8_dpath
// Bin memory, sample counter, cumulative scan and result register.
// ----------------------------------------------------------------------------
module hm8_dpath #(
    parameter int MAX_COUNT = hm8_pkg::MAX_COUNT_DEF,
    parameter int NUM_BINS  = hm8_pkg::NUM_BINS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hm8_pkg::t_cmd                i_cmd,
    output hm8_pkg::t_sts                o_sts,
    input  logic [hm8_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [hm8_pkg::OUT_W-1:0]    o_median_doubled,
    output logic [hm8_pkg::OUT_W-1:0]    o_set_size,
    output logic                         o_overflowed
);
    import hm8_pkg::*;

    localparam int CNT_W = $clog2(MAX_COUNT + 1);
    localparam int IDX_W = $clog2(NUM_BINS);

    logic [CNT_W-1:0] mem [NUM_BINS];

    logic [IDX_W-1:0]    sample_addr;
    logic [IDX_W-1:0]    rd_addr;
    logic                we;
    logic [IDX_W-1:0]    wr_addr;
    logic [CNT_W-1:0]    wr_data;
    logic [CNT_W-1:0]    r_rd_data;

    logic [CNT_W-1:0]    r_count;
    logic                r_ovf;
    logic                r_inc_en;
    logic [IDX_W-1:0]    r_inc_addr;
    logic [IDX_W-1:0]    r_scan_idx;
    logic [IDX_W-1:0]    r_data_idx;
    logic                r_data_vld;
    logic [CNT_W-1:0]    r_cum;
    logic                r_lo_found, r_hi_found;
    logic [SAMPLE_W-1:0] r_lo_val, r_hi_val;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_median, r_size;
    logic                r_out_ovf;

    logic [CNT_W-1:0]    half, rank_hi, rank_lo, cum_nx;
    logic                sweep, sweep_last;

    always_comb begin
        if (int'(i_sample_value) >= NUM_BINS) begin
            sample_addr = IDX_W'(NUM_BINS - 1);
        end else begin
            sample_addr = IDX_W'(i_sample_value);
        end
    end

    assign sweep      = i_cmd.scan || i_cmd.clear;
    assign sweep_last = (r_scan_idx == IDX_W'(NUM_BINS - 1));
    assign rd_addr    = sweep ? r_scan_idx : sample_addr;
    assign we         = sweep || (i_cmd.inc && r_inc_en);
    assign wr_addr    = sweep ? r_scan_idx : r_inc_addr;
    assign wr_data    = sweep ? '0 : r_rd_data + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (we) mem[wr_addr] <= wr_data;
        r_rd_data <= mem[rd_addr];
    end

    assign half    = r_count >> 1;
    assign rank_hi = half + CNT_W'(1);
    assign rank_lo = r_count[0] ? rank_hi : half;
    assign cum_nx  = r_cum + r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_inc_en    <= 1'b0;
            r_scan_idx  <= '0;
            r_data_vld  <= 1'b0;
            r_cum       <= '0;
            r_lo_found  <= 1'b0;
            r_hi_found  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                if (r_count < CNT_W'(MAX_COUNT)) begin
                    r_count  <= r_count + CNT_W'(1);
                    r_inc_en <= 1'b1;
                end else begin
                    r_ovf    <= 1'b1;
                    r_inc_en <= 1'b0;
                end
            end
            if (sweep) begin
                r_scan_idx <= sweep_last ? '0 : r_scan_idx + IDX_W'(1);
            end
            r_data_vld <= i_cmd.scan;
            if (r_data_vld) begin
                r_cum <= cum_nx;
                if (!r_lo_found && cum_nx >= rank_lo) r_lo_found <= 1'b1;
                if (!r_hi_found && cum_nx >= rank_hi) r_hi_found <= 1'b1;
            end
            if (i_cmd.load) begin
                r_count     <= '0;
                r_ovf       <= 1'b0;
                r_cum       <= '0;
                r_lo_found  <= 1'b0;
                r_hi_found  <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_inc_addr <= sample_addr;
        r_data_idx <= r_scan_idx;
        if (r_data_vld) begin
            if (!r_lo_found && cum_nx >= rank_lo) r_lo_val <= SAMPLE_W'(r_data_idx);
            if (!r_hi_found && cum_nx >= rank_hi) r_hi_val <= SAMPLE_W'(r_data_idx);
        end
        if (i_cmd.load) begin
            r_median  <= {1'b0, (r_lo_found ? r_lo_val : SAMPLE_W'(0))}
                       + {1'b0, (r_hi_found ? r_hi_val : SAMPLE_W'(0))};
            r_size    <= OUT_W'(r_count);
            r_out_ovf <= r_ovf;
        end
    end

    assign o_sts.sweep_last = sweep_last;
    assign o_sts.out_free   = !r_out_valid || !i_stall;

    assign o_valid          = r_out_valid;
    assign o_median_doubled = r_median;
    assign o_set_size       = r_size;
    assign o_overflowed     = r_out_ovf;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_COUNT))
        else $error("sample count beyond limit");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> o_sts.out_free)
        else $error("result overwritten before taken");
    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_count == '0 && !r_ovf && r_cum == '0))
        else $error("set state not cleared after result");
    a_data_follows_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_data_vld |-> $past(i_cmd.scan))
        else $error("scan data without scan read");
`endif

endmodule

// ----- tb/sv/tb_histogram_median_8bit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_histogram_median_8bit
// Self-checking testbench for the histogram median block.
// ----------------------------------------------------------------------------
// Sets of 8-bit samples are sent beat by beat. A local histogram tracks each
// set and predicts twice the median, the counted size and the overflow flag
// when the closing beat is taken. Every result beat is checked against the
// oldest prediction. Covers extreme values, odd and even sets, sets at and
// past the count limit, random sets under several idle/stall mixes, and a
// long output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_histogram_median_8bit;

    import hm8_pkg::*;

    localparam int MAX_CNT   = MAX_COUNT_DEF;
    localparam int BINS      = NUM_BINS_DEF;
    localparam int SCAN_LAT  = BINS + 16;

    typedef struct {
        logic [OUT_W-1:0] median_doubled;
        logic [OUT_W-1:0] set_size;
        logic             overflowed;
    } t_median_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [SAMPLE_W-1:0] i_sample_value;
    logic                i_last_item;
    logic                o_valid;
    logic                i_stall;
    logic [OUT_W-1:0]    o_median_doubled;
    logic [OUT_W-1:0]    o_set_size;
    logic                o_overflowed;

    // local histogram of the open set
    int unsigned    hist_bins [BINS];
    int unsigned    hist_count;
    bit             hist_overflow;
    t_median_result pending_medians [$];

    int idle_pct;
    int stall_pct;
    int hold_left;
    int fail_count;
    int items_sent;
    int sets_checked;
    int overflow_sets;
    int input_stall_cycles;

    histogram_median_8bit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_sample_value   (i_sample_value),
        .i_last_item      (i_last_item),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_median_doubled (o_median_doubled),
        .o_set_size       (o_set_size),
        .o_overflowed     (o_overflowed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned rank_lookup(int unsigned rank);
        int unsigned cum;
        cum = 0;
        for (int i = 0; i < BINS; i++) begin
            cum += hist_bins[i];
            if (cum >= rank) return i;
        end
        return 0;
    endfunction

    task automatic clear_histogram();
        foreach (hist_bins[i]) hist_bins[i] = 0;
        hist_count    = 0;
        hist_overflow = 0;
    endtask

    task automatic predict_sample(input logic [SAMPLE_W-1:0] value, input logic last);
        int unsigned    bin;
        int unsigned    n;
        int unsigned    doubled;
        t_median_result res;
        bin = value;
        if (bin >= BINS) bin = BINS - 1;
        if (hist_count < MAX_CNT) begin
            hist_bins[bin]++;
            hist_count++;
        end else begin
            hist_overflow = 1;
        end
        if (!last) return;
        n = hist_count;
        if (n == 0) doubled = 0;
        else if (n % 2 == 1) doubled = 2 * rank_lookup(n / 2 + 1);
        else doubled = rank_lookup(n / 2) + rank_lookup(n / 2 + 1);
        res.median_doubled = doubled[OUT_W-1:0];
        res.set_size       = n[OUT_W-1:0];
        res.overflowed     = hist_overflow;
        if (hist_overflow) overflow_sets++;
        pending_medians = {pending_medians, res};
        clear_histogram();
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_median_result exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_medians.size() == 0) begin
                $error("result beat with no expectation: median_doubled %0d set_size %0d",
                       o_median_doubled, o_set_size);
                fail_count++;
            end else begin
                exp_res = pending_medians.pop_front();
                sets_checked++;
                if (o_median_doubled !== exp_res.median_doubled) begin
                    $error("median_doubled: expected %0d, got %0d",
                           exp_res.median_doubled, o_median_doubled);
                    fail_count++;
                end
                if (o_set_size !== exp_res.set_size) begin
                    $error("set_size: expected %0d, got %0d", exp_res.set_size, o_set_size);
                    fail_count++;
                end
                if (o_overflowed !== exp_res.overflowed) begin
                    $error("overflowed: expected %0d, got %0d",
                           exp_res.overflowed, o_overflowed);
                    fail_count++;
                end
            end
        end
        if (i_rst_n && i_valid && o_stall) input_stall_cycles++;
    end

    // receiver side
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic last);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_sample_value <= value;
        i_last_item    <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_sample(value, last);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_medians.size() > 0) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(int mode, logic [SAMPLE_W-1:0] base);
        case (mode)
            0: return SAMPLE_W'($urandom_range(255));
            1: return SAMPLE_W'(base + $urandom_range(3));
            default: return $urandom_range(1) ? 8'hFF : 8'h00;
        endcase
    endfunction

    task automatic send_set(input int size, input int mode);
        logic [SAMPLE_W-1:0] base;
        base = SAMPLE_W'($urandom_range(255));
        for (int i = 0; i < size; i++) send_sample(pick_sample(mode, base), i == size - 1);
    endtask

    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        send_sample(8'd0, 1'b1);
        send_sample(8'd255, 1'b1);
        send_sample(8'd0, 1'b0);
        send_sample(8'd255, 1'b1);
        send_sample(8'd255, 1'b0);
        send_sample(8'd255, 1'b1);
        send_sample(8'd255, 1'b0);
        send_sample(8'd0, 1'b0);
        send_sample(8'd128, 1'b1);
        send_sample(8'd30, 1'b0);
        send_sample(8'd11, 1'b0);
        send_sample(8'd20, 1'b0);
        send_sample(8'd10, 1'b1);
        send_sample(8'h55, 1'b0);
        send_sample(8'hAA, 1'b0);
        send_sample(8'h55, 1'b0);
        send_sample(8'hAA, 1'b1);
        send_sample(8'd1, 1'b0);
        send_sample(8'd254, 1'b1);
        wait_drained();
    endtask

    // sets at and past the count limit, incl. a dropped closing sample
    task automatic test_set_too_long();
        idle_pct  = 0;
        stall_pct = 0;
        send_set(MAX_CNT, 0);
        send_set(MAX_CNT + 1, 2);
        send_set(MAX_CNT + 40, 1);
        wait_drained();
    endtask

    task automatic test_random_phase(input int n_items, input int idle, input int stall);
        int start;
        int sel;
        int size;
        idle_pct  = idle;
        stall_pct = stall;
        start     = items_sent;
        while (items_sent - start < n_items) begin
            sel = $urandom_range(99);
            if (sel < 90) size = $urandom_range(12, 1);
            else if (sel < 98) size = $urandom_range(MAX_CNT, 13);
            else size = $urandom_range(MAX_CNT + 14, MAX_CNT + 1);
            send_set(size, $urandom_range(2));
        end
        wait_drained();
    endtask

    // long output hold-off while input keeps coming
    task automatic test_output_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 3 * SCAN_LAT + 600;
        for (int s = 0; s < 4; s++) send_set($urandom_range(8, 2), 0);
        send_set(20, 1);
        wait_drained();
        stall_pct = 40;
        for (int s = 0; s < 6; s++) send_set(1, 0);
        wait_drained();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_sample_value = '0;
        i_last_item    = 1'b0;
        idle_pct       = 0;
        stall_pct      = 0;
        hold_left      = 0;
        fail_count     = 0;
        items_sent     = 0;
        sets_checked   = 0;
        overflow_sets  = 0;
        input_stall_cycles = 0;
        clear_histogram();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_set_too_long();
        test_random_phase(110, 0, 0);
        test_random_phase(110, 62, 0);
        test_random_phase(110, 0, 62);
        test_random_phase(110, 28, 28);
        test_output_backpressure();

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait_drained();
        repeat (SCAN_LAT) @(posedge i_clk);

        $display("Sent %0d samples; %0d sets checked, %0d of them past the count limit.",
                 items_sent, sets_checked, overflow_sets);
        $display("Input held off for %0d cycles under idle/stall mixes and output hold-off.",
                 input_stall_cycles);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/hm8_pkg.sv
rtl/core/hm8_ctrl.sv
rtl/core/hm8_dpath.sv
rtl/core/histogram_median_8bit.sv
tb/sv/tb_histogram_median_8bit.sv
